FILE: rtl/etmb_pkg.sv
// Shared types, constants and helper functions of the Euler transform matrix builder.
// No dependencies.
package etmb_pkg;

    localparam int TrigIter  = 16;
    localparam int AtanLen   = 24;
    localparam int AtanIdxW  = 5;
    localparam int IterW     = (TrigIter > 1) ? $clog2(TrigIter) : 1;

    localparam logic signed [32:0] InvGain = 33'sh026DD3B6A;
    localparam logic signed [31:0] OneQ16  = 32'sd65536;
    localparam logic signed [31:0] SatMax  = 32'sh7FFFFFFF;

    typedef logic signed [17:0] t_sc;   // sine / cosine, Q16 in [-1, 1]
    typedef logic signed [19:0] t_q;    // rotation terms, Q16

    typedef struct packed {
        logic signed [15:0]       angle_x;
        logic signed [15:0]       angle_y;
        logic signed [15:0]       angle_z;
        logic [2:0][15:0]         scale;      // raw Q8.8, index 0 = x
        logic [2:0][15:0]         scale_mag;
        logic [2:0]               scale_neg;
        logic [2:0]               scale_zero;
        logic signed [31:0]       move_x;
        logic signed [31:0]       move_y;
        logic signed [31:0]       move_z;
    } t_item;

    function automatic logic signed [31:0] atan_q30(input logic [AtanIdxW-1:0] idx);
        case (idx)
            5'd0:    return 32'h20000000;
            5'd1:    return 32'h12E4051D;
            5'd2:    return 32'h09FB385B;
            5'd3:    return 32'h051111D4;
            5'd4:    return 32'h028B0D43;
            5'd5:    return 32'h0145D7E1;
            5'd6:    return 32'h00A2F61E;
            5'd7:    return 32'h00517C55;
            5'd8:    return 32'h0028BE53;
            5'd9:    return 32'h00145F2E;
            5'd10:   return 32'h000A2F98;
            5'd11:   return 32'h000517CC;
            5'd12:   return 32'h00028BE6;
            5'd13:   return 32'h000145F3;
            5'd14:   return 32'h0000A2F9;
            5'd15:   return 32'h0000517C;
            5'd16:   return 32'h000028BE;
            5'd17:   return 32'h0000145F;
            5'd18:   return 32'h00000A2F;
            5'd19:   return 32'h00000517;
            5'd20:   return 32'h0000028B;
            5'd21:   return 32'h00000145;
            5'd22:   return 32'h000000A2;
            5'd23:   return 32'h00000051;
            default: return 32'h00000000;
        endcase
    endfunction

    // Round a column product and saturate: model uses Q8.8 x Q16, normal Q16 x Q16.
    function automatic logic signed [31:0] sat_round(input logic signed [52:0] p,
                                                     input logic model);
        logic signed [53:0] s;
        logic signed [53:0] v;
        s = model ? (54'(p) + 54'sd128) : (54'(p) + 54'sd32768);
        v = model ? (s >>> 8) : (s >>> 16);
        if (v > 54'sd2147483647) begin
            return SatMax;
        end else if (v < -54'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

FILE: rtl/euler_transform_matrix_builder.sv
// Euler transform matrix builder top level: back-end sequencer, multipliers, result register.
// Depends on etmb_pkg, etmb_front, etmb_cordic, etmb_recip.
//
// Each input beat (three binary angles, Q8.8 scales, Q16.16 moves) yields seven result
// beats: model columns 0..3 (Translate*Ry*Rx*Rz*Scale), then normal columns 0..2 with
// the last flag on the seventh. A two-entry queue in the front accepts and classifies
// beats while the back end works, so input and output stall independently. The back
// end picks up an item from the queue, then runs three trig/reciprocal phases (CORDIC
// of TrigIter steps alongside a 25-step divider; each phase is paced by the divider:
// start, 25 steps, done register, hand-off), shared-multiplier microcode for the
// rotation terms, a sum state, then a multiply state and a load state per column; a
// result beat that waits for ready holds the back end. A zero scale gives a reciprocal
// of 0x7FFFFFFF and div_fault on that normal column.
module euler_transform_matrix_builder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [15:0]   i_angle_x,
    input  logic signed [15:0]   i_angle_y,
    input  logic signed [15:0]   i_angle_z,
    input  logic signed [15:0]   i_scale_x,
    input  logic signed [15:0]   i_scale_y,
    input  logic signed [15:0]   i_scale_z,
    input  logic signed [31:0]   i_move_x,
    input  logic signed [31:0]   i_move_y,
    input  logic signed [31:0]   i_move_z,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_matrix_kind,
    output logic [1:0]           o_column_index,
    output logic signed [31:0]   o_elem_0,
    output logic signed [31:0]   o_elem_1,
    output logic signed [31:0]   o_elem_2,
    output logic signed [31:0]   o_elem_3,
    output logic                 o_div_fault,
    output logic                 o_last
);

    typedef enum logic [2:0] {S_IDLE, S_TRIG, S_MUL, S_SUM, S_CMUL, S_CLD} t_state;

    t_state                r_state;
    etmb_pkg::t_item       in_item;
    etmb_pkg::t_item       f_item;
    etmb_pkg::t_item       r_item;
    logic                  f_valid;
    logic                  pop;

    // trig / reciprocal phase
    logic [1:0]            r_phase;
    logic                  r_start;
    logic                  r_cdone;
    logic                  r_ddone;
    logic                  phase_end;
    logic signed [15:0]    c_angle;
    logic                  c_done;
    etmb_pkg::t_sc         c_sin;
    etmb_pkg::t_sc         c_cos;
    logic                  d_done;
    logic signed [31:0]    d_inv;
    etmb_pkg::t_sc         r_s1, r_c1, r_s2, r_c2, r_s3, r_c3;
    logic signed [31:0]    r_inv [0:2];

    // rotation-term microcode
    logic [3:0]            r_k;
    logic                  r_ph;
    etmb_pkg::t_q          ma;
    etmb_pkg::t_q          mb;
    logic signed [39:0]    r_mprod;
    logic signed [39:0]    mround;
    etmb_pkg::t_q          mres;
    etmb_pkg::t_q          r_pa, r_pb, r_pc, r_pd, r_pe, r_pf;
    etmb_pkg::t_q          r_t1, r_t2, r_t3, r_t4;
    etmb_pkg::t_q          r_r00, r_r01, r_r02, r_r10, r_r11, r_r12, r_r20, r_r21, r_r22;

    // column lanes
    logic [2:0]            r_col;
    logic [1:0]            cj;
    logic                  kind;
    logic signed [32:0]    opa;
    etmb_pkg::t_q          rs [0:2];
    logic signed [52:0]    r_lp [0:2];
    logic                  oslot;

    assign in_item.angle_x    = i_angle_x;
    assign in_item.angle_y    = i_angle_y;
    assign in_item.angle_z    = i_angle_z;
    assign in_item.scale      = {i_scale_z, i_scale_y, i_scale_x};
    assign in_item.scale_mag  = '0;
    assign in_item.scale_neg  = '0;
    assign in_item.scale_zero = '0;
    assign in_item.move_x     = i_move_x;
    assign in_item.move_y     = i_move_y;
    assign in_item.move_z     = i_move_z;

    etmb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_item       (in_item),
        .o_item_valid (f_valid),
        .i_item_pop   (pop),
        .o_item       (f_item)
    );

    assign pop       = (r_state == S_IDLE) && f_valid;
    assign phase_end = (r_state == S_TRIG) && r_cdone && r_ddone;

    // Phase order: angle y with scale x, angle x with scale y, angle z with scale z.
    always_comb begin
        case (r_phase)
            2'd0:    c_angle = r_item.angle_y;
            2'd1:    c_angle = r_item.angle_x;
            default: c_angle = r_item.angle_z;
        endcase
    end

    etmb_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_angle (c_angle),
        .o_done  (c_done),
        .o_sin   (c_sin),
        .o_cos   (c_cos)
    );

    etmb_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_mag   (r_item.scale_mag[r_phase]),
        .i_neg   (r_item.scale_neg[r_phase]),
        .i_zero  (r_item.scale_zero[r_phase]),
        .o_done  (d_done),
        .o_inv   (d_inv)
    );

    // Operand select for the shared Q16 multiplier.
    always_comb begin
        case (r_k)
            4'd0:    begin ma = etmb_pkg::t_q'(r_c1); mb = etmb_pkg::t_q'(r_c3); end
            4'd1:    begin ma = etmb_pkg::t_q'(r_s1); mb = etmb_pkg::t_q'(r_s2); end
            4'd2:    begin ma = r_pb;                 mb = etmb_pkg::t_q'(r_s3); end
            4'd3:    begin ma = etmb_pkg::t_q'(r_c2); mb = etmb_pkg::t_q'(r_s3); end
            4'd4:    begin ma = etmb_pkg::t_q'(r_c1); mb = etmb_pkg::t_q'(r_s2); end
            4'd5:    begin ma = r_pc;                 mb = etmb_pkg::t_q'(r_s3); end
            4'd6:    begin ma = etmb_pkg::t_q'(r_c3); mb = etmb_pkg::t_q'(r_s1); end
            4'd7:    begin ma = r_pd;                 mb = etmb_pkg::t_q'(r_s2); end
            4'd8:    begin ma = etmb_pkg::t_q'(r_c1); mb = etmb_pkg::t_q'(r_s3); end
            4'd9:    begin ma = etmb_pkg::t_q'(r_c2); mb = etmb_pkg::t_q'(r_c3); end
            4'd10:   begin ma = r_pa;                 mb = etmb_pkg::t_q'(r_s2); end
            4'd11:   begin ma = etmb_pkg::t_q'(r_s1); mb = etmb_pkg::t_q'(r_s3); end
            4'd12:   begin ma = etmb_pkg::t_q'(r_c2); mb = etmb_pkg::t_q'(r_s1); end
            4'd13:   begin ma = etmb_pkg::t_q'(r_c1); mb = etmb_pkg::t_q'(r_c2); end
            default: begin ma = '0;                   mb = '0;                   end
        endcase
    end

    assign mround = (r_mprod + 40'sd32768) >>> 16;
    assign mres   = mround[19:0];

    // Column lanes: j = column within its matrix, bit 2 of the count picks normal.
    assign cj   = r_col[1:0];
    assign kind = r_col[2];
    assign opa  = kind ? 33'(r_inv[cj]) : 33'($signed(r_item.scale[cj]));

    always_comb begin
        case (cj)
            2'd0:    begin rs[0] = r_r00; rs[1] = r_r01; rs[2] = r_r02; end
            2'd1:    begin rs[0] = r_r10; rs[1] = r_r11; rs[2] = r_r12; end
            2'd2:    begin rs[0] = r_r20; rs[1] = r_r21; rs[2] = r_r22; end
            default: begin rs[0] = '0;    rs[1] = '0;    rs[2] = '0;    end
        endcase
    end

    assign oslot = !o_valid || i_ready;

    always_ff @(posedge i_clk) begin
        // payload
        if (pop) begin
            r_item <= f_item;
        end
        if (c_done) begin
            case (r_phase)
                2'd0:    begin r_s1 <= c_sin; r_c1 <= c_cos; end
                2'd1:    begin r_s2 <= c_sin; r_c2 <= c_cos; end
                default: begin r_s3 <= c_sin; r_c3 <= c_cos; end
            endcase
        end
        if (d_done) begin
            r_inv[r_phase] <= d_inv;
        end
        if (r_state == S_MUL) begin
            if (!r_ph) begin
                r_mprod <= ma * mb;
            end else begin
                case (r_k)
                    4'd0:    r_pa  <= mres;
                    4'd1:    r_pb  <= mres;
                    4'd2:    r_t1  <= mres;
                    4'd3:    r_r01 <= mres;
                    4'd4:    r_pc  <= mres;
                    4'd5:    r_t2  <= mres;
                    4'd6:    r_pd  <= mres;
                    4'd7:    r_t3  <= mres;
                    4'd8:    r_pe  <= mres;
                    4'd9:    r_r11 <= mres;
                    4'd10:   r_t4  <= mres;
                    4'd11:   r_pf  <= mres;
                    4'd12:   r_r20 <= mres;
                    default: r_r22 <= mres;
                endcase
            end
        end
        if (r_state == S_SUM) begin
            r_r00 <= r_pa + r_t1;
            r_r02 <= r_t2 - r_pd;
            r_r10 <= r_t3 - r_pe;
            r_r12 <= r_t4 + r_pf;
            r_r21 <= -etmb_pkg::t_q'(r_s2);
        end
        if (r_state == S_CMUL) begin
            for (int k = 0; k < 3; k++) begin
                r_lp[k] <= opa * rs[k];
            end
        end
        if (r_state == S_CLD && oslot) begin
            o_matrix_kind  <= kind;
            o_column_index <= cj;
            o_last         <= (r_col == 3'd6);
            o_div_fault    <= kind && r_item.scale_zero[cj];
            if (r_col == 3'd3) begin
                o_elem_0 <= r_item.move_x;
                o_elem_1 <= r_item.move_y;
                o_elem_2 <= r_item.move_z;
                o_elem_3 <= etmb_pkg::OneQ16;
            end else begin
                o_elem_0 <= etmb_pkg::sat_round(r_lp[0], !kind);
                o_elem_1 <= etmb_pkg::sat_round(r_lp[1], !kind);
                o_elem_2 <= etmb_pkg::sat_round(r_lp[2], !kind);
                o_elem_3 <= '0;
            end
        end

        // control
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= 2'd0;
            r_start <= 1'b0;
            r_cdone <= 1'b0;
            r_ddone <= 1'b0;
            r_k     <= 4'd0;
            r_ph    <= 1'b0;
            r_col   <= 3'd0;
            o_valid <= 1'b0;
        end else begin
            // start pulse: new item, or the next phase of the current one
            r_start <= pop || (phase_end && (r_phase != 2'd2));
            if (pop || phase_end) begin
                r_cdone <= 1'b0;
            end else if (c_done) begin
                r_cdone <= 1'b1;
            end
            if (pop || phase_end) begin
                r_ddone <= 1'b0;
            end else if (d_done) begin
                r_ddone <= 1'b1;
            end
            if (r_state == S_CLD && oslot) begin
                o_valid <= 1'b1;
            end else if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (f_valid) begin
                        r_phase <= 2'd0;
                        r_state <= S_TRIG;
                    end
                end
                S_TRIG: begin
                    if (phase_end) begin
                        if (r_phase == 2'd2) begin
                            r_k     <= 4'd0;
                            r_ph    <= 1'b0;
                            r_state <= S_MUL;
                        end else begin
                            r_phase <= r_phase + 2'd1;
                        end
                    end
                end
                S_MUL: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        if (r_k == 4'd13) begin
                            r_state <= S_SUM;
                        end else begin
                            r_k <= r_k + 4'd1;
                        end
                    end
                end
                S_SUM: begin
                    r_col   <= 3'd0;
                    r_state <= S_CMUL;
                end
                S_CMUL: begin
                    r_state <= S_CLD;
                end
                S_CLD: begin
                    if (oslot) begin
                        if (r_col == 3'd6) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_col   <= r_col + 3'd1;
                            r_state <= S_CMUL;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_last_is_normal2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_matrix_kind && (o_column_index == 2'd2))
        else $error("last beat is not normal column 2");

    a_fault_normal_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_div_fault |-> o_matrix_kind)
        else $error("div_fault on a model column");

    a_move_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_matrix_kind && (o_column_index == 2'd3)
        |-> (o_elem_3 == etmb_pkg::OneQ16))
        else $error("translation column lacks unit w");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !pop)
        else $error("item taken from queue while back end busy");

endmodule

FILE: rtl/etmb_front.sv
// Front end: accepts input beats, classifies the scales and queues items.
// Depends on etmb_pkg.
module etmb_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  etmb_pkg::t_item      i_item,
    output logic                 o_item_valid,
    input  logic                 i_item_pop,
    output etmb_pkg::t_item      o_item
);

    etmb_pkg::t_item r_mem [0:1];
    logic            r_wr;
    logic            r_rd;
    logic [1:0]      r_cnt;
    etmb_pkg::t_item cls;
    logic            push;

    assign o_ready      = (r_cnt != 2'd2);
    assign push         = i_valid && o_ready;
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_mem[r_rd];

    always_comb begin
        cls = i_item;
        for (int j = 0; j < 3; j++) begin
            cls.scale_neg[j]  = i_item.scale[j][15];
            cls.scale_zero[j] = (i_item.scale[j] == 16'h0000);
            cls.scale_mag[j]  = i_item.scale[j][15] ? (16'h0000 - i_item.scale[j])
                                                    : i_item.scale[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= cls;
        end
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (i_item_pop && o_item_valid) begin
                r_rd <= ~r_rd;
            end
            case ({push, i_item_pop && o_item_valid})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: rtl/etmb_cordic.sv
// Iterative rotation-mode CORDIC: sine and cosine of a binary angle, one step a cycle.
// Depends on etmb_pkg.
module etmb_cordic (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [15:0]   i_angle,
    output logic                 o_done,
    output etmb_pkg::t_sc        o_sin,
    output etmb_pkg::t_sc        o_cos
);

    logic signed [32:0]            r_x;
    logic signed [32:0]            r_y;
    logic signed [31:0]            r_z;
    logic [1:0]                    r_quad;
    logic [etmb_pkg::IterW-1:0]    r_i;
    logic                          r_busy;
    logic                          r_fin;
    logic [15:0]                   t;
    logic signed [15:0]            zr;
    logic signed [32:0]            dx;
    logic signed [32:0]            dy;
    logic signed [31:0]            at;
    etmb_pkg::t_sc                 cs;
    etmb_pkg::t_sc                 sn;

    function automatic etmb_pkg::t_sc clamp_unit(input logic signed [32:0] v);
        logic signed [32:0] r;
        r = (v + 33'sd8192) >>> 14;
        if (r > 33'sd65536) begin
            return 18'sd65536;
        end else if (r < -33'sd65536) begin
            return -18'sd65536;
        end else begin
            return r[17:0];
        end
    endfunction

    assign t  = i_angle + 16'h2000;
    assign zr = $signed({2'b00, t[13:0]}) - 16'sd8192;
    assign dx = r_y >>> r_i;
    assign dy = r_x >>> r_i;
    assign at = etmb_pkg::atan_q30(etmb_pkg::AtanIdxW'(r_i));
    assign cs = clamp_unit(r_x);
    assign sn = clamp_unit(r_y);
    assign o_done = r_fin;

    always_comb begin
        case (r_quad)
            2'd0:    begin o_cos = cs;  o_sin = sn;  end
            2'd1:    begin o_cos = -sn; o_sin = cs;  end
            2'd2:    begin o_cos = -cs; o_sin = -sn; end
            default: begin o_cos = sn;  o_sin = -cs; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quad <= t[15:14];
            r_z    <= {zr, 16'h0000};
            r_x    <= etmb_pkg::InvGain;
            r_y    <= '0;
        end else if (r_busy) begin
            if (!r_z[31]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + at;
            end
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_i    <= '0;
        end else begin
            r_fin <= r_busy && (r_i == etmb_pkg::IterW'(etmb_pkg::TrigIter - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                if (r_i == etmb_pkg::IterW'(etmb_pkg::TrigIter - 1)) begin
                    r_busy <= 1'b0;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
        end
    end

endmodule

FILE: rtl/etmb_recip.sv
// Restoring divider for the Q16.16 reciprocal 2^24/|scale|, one quotient bit a cycle.
// Depends on etmb_pkg.
module etmb_recip (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [15:0]          i_mag,
    input  logic                 i_neg,
    input  logic                 i_zero,
    output logic                 o_done,
    output logic signed [31:0]   o_inv
);

    logic [15:0]  r_d;
    logic [16:0]  r_rem;
    logic [24:0]  r_q;
    logic [4:0]   r_n;
    logic         r_neg;
    logic         r_zero;
    logic         r_busy;
    logic [17:0]  tr;
    logic         qb;

    // Dividend is 2^24: its first bit is one, the rest zero.
    assign tr = {r_rem, (r_n == 5'd0)};
    assign qb = (tr >= {2'b00, r_d});

    // Quotient is complete when o_done rises and holds until the next start.
    assign o_inv = r_zero ? etmb_pkg::SatMax
                 : (r_neg ? -$signed({7'd0, r_q}) : $signed({7'd0, r_q}));

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_d    <= i_mag;
            r_neg  <= i_neg;
            r_zero <= i_zero;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_rem <= qb ? 17'(tr - {2'b00, r_d}) : tr[16:0];
            r_q   <= {r_q[23:0], qb};
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_n    <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= r_busy && !i_start && (r_n == 5'd24);
            if (i_start) begin
                r_busy <= 1'b1;
                r_n    <= '0;
            end else if (r_busy) begin
                r_n <= r_n + 5'd1;
                if (r_n == 5'd24) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule
